// ===== sv/firlp_pkg.sv =====
package firlp_pkg;

    // Default build of the filter.
    localparam int TAP_COUNT_DEF   = 29;
    localparam int SAMPLE_BITS_DEF = 18;

    // Fixed widths of the beat fields.
    localparam int IN_SAMPLE_W = 18;
    localparam int OUT_W       = 20;

    // Coefficients are Q1.15; the tap index is wide enough for the largest filter.
    localparam int COEF_W     = 16;
    localparam int COEF_COUNT = 29;
    localparam int COEF_IDX_W = 6;
    localparam int FRAC_BITS  = 15;

    localparam logic signed [COEF_W-1:0] LP_COEF [COEF_COUNT] = '{
        -16'sd51,   -16'sd72,   -16'sd108,  -16'sd145,  -16'sd156,
        -16'sd99,    16'sd72,    16'sd389,   16'sd864,   16'sd1474,
         16'sd2161,  16'sd2843,  16'sd3423,  16'sd3813,  16'sd3950,
         16'sd3813,  16'sd3423,  16'sd2843,  16'sd2161,  16'sd1474,
         16'sd864,   16'sd389,   16'sd72,   -16'sd99,   -16'sd156,
        -16'sd145,  -16'sd108,  -16'sd72,   -16'sd51
    };

    typedef struct packed {
        logic                   channel;
        logic [IN_SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic                    result_channel;
        logic signed [OUT_W-1:0] filtered;
    } t_out_beat;

    // Taps past the end of the table have a zero coefficient.
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < COEF_IDX_W'(COEF_COUNT)) begin
            c = LP_COEF[idx[4:0]];
        end
        return c;
    endfunction

endpackage

// ===== sv/fir_lowpass_29tap_dual_top.sv =====
// Channel  Direction  Payload                        Handshake
// in       input      firlp_pkg::t_in_beat           i_in_valid / o_in_stall
// out      output     firlp_pkg::t_out_beat          o_out_valid / i_out_stall
//
// Each input beat runs through the whole tap sweep, the flush and the finishing state
// before the next one can be accepted; a single shared multiplier works through one tap per cycle.
// The selected delay line rotates past the multiplier one word per cycle, so the
// coefficient step count sets the throughput.
// The result beat is written from the finishing state into an output
// register, so a stall on the output side only blocks the block when a second result
// is ready to be written.
// Reset is synchronous and active low; it clears both delay lines to zero.
module fir_lowpass_29tap_dual_top #(
    parameter int TAP_COUNT   = firlp_pkg::TAP_COUNT_DEF,
    parameter int SAMPLE_BITS = firlp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  firlp_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output firlp_pkg::t_out_beat o_out_data
);

    // Depth of each channel's delay line; the newest sample is tap zero.
    localparam int DEPTH  = TAP_COUNT - 1;
    localparam int IDX_W  = $clog2(TAP_COUNT);
    localparam int CI_W   = firlp_pkg::COEF_IDX_W;
    localparam int COEF_W = firlp_pkg::COEF_W;
    localparam int OUT_W  = firlp_pkg::OUT_W;
    localparam int FRAC   = firlp_pkg::FRAC_BITS;
    // The unsigned sample gains a sign bit before it meets the signed coefficient.
    localparam int PROD_W = SAMPLE_BITS + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
    // The rounding path is wide enough for both the accumulator and the saturation limits.
    localparam int RND_W  = (ACC_W + 1 > OUT_W + FRAC + 1) ? ACC_W + 1 : OUT_W + FRAC + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAP_COUNT - 1);

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1 << (FRAC - 1));
    localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_MIN  = -RND_W'(1 << (OUT_W - 1));

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_ch;
    logic [SAMPLE_BITS-1:0] r_x;

    logic [SAMPLE_BITS-1:0] r_hist_ir [DEPTH];
    logic [SAMPLE_BITS-1:0] r_hist_rd [DEPTH];

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                 r_out_vld;
    firlp_pkg::t_out_beat r_out;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic [SAMPLE_BITS-1:0]   w_head;
    logic [SAMPLE_BITS-1:0]   w_opnd;
    logic [SAMPLE_BITS-1:0]   w_feed;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [RND_W-1:0]  w_q;
    logic signed [OUT_W-1:0]  w_filt;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_vld || !i_out_stall;

    // The far end of the active line is the word that passes the multiplier.
    assign w_head = r_ch ? r_hist_rd[DEPTH-1] : r_hist_ir[DEPTH-1];

    // The count runs from the oldest tap down to zero. On the first step the new sample
    // enters the line and the oldest word falls off; after that the line rotates, so it
    // is back in order when the count reaches zero. Tap zero is the held sample.
    assign w_opnd = (r_idx == '0) ? r_x : w_head;
    assign w_feed = (r_idx == LAST_IDX) ? r_x : w_head;
    assign w_coef = firlp_pkg::coef_at(CI_W'(r_idx));
    assign w_prod = $signed({1'b0, w_opnd}) * w_coef;

    // Round half up, then clamp to the signed output range.
    assign w_rnd = RND_W'(r_acc) + RND_HALF;
    assign w_q   = w_rnd >>> FRAC;

    always_comb begin
        if (w_q > SAT_MAX) begin
            w_filt = OUT_W'(SAT_MAX);
        end else if (w_q < SAT_MIN) begin
            w_filt = OUT_W'(SAT_MIN);
        end else begin
            w_filt = OUT_W'(w_q);
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_MAC;
                    n_idx   = LAST_IDX;
                end
            end
            S_MAC: begin
                if (r_idx == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Input hold register.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x  <= SAMPLE_BITS'(i_in_data.sample);
            r_ch <= i_in_data.channel;
        end
    end

    // Delay lines: only the selected channel moves, one word per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_hist_ir[i] <= '0;
                r_hist_rd[i] <= '0;
            end
        end else if (r_state == S_MAC) begin
            if (r_ch) begin
                r_hist_rd[0] <= w_feed;
                for (int i = 1; i < DEPTH; i++) begin
                    r_hist_rd[i] <= r_hist_rd[i-1];
                end
            end else begin
                r_hist_ir[0] <= w_feed;
                for (int i = 1; i < DEPTH; i++) begin
                    r_hist_ir[i] <= r_hist_ir[i-1];
                end
            end
        end
    end

    // Multiply, then accumulate the registered product in the next cycle. The product register starts at zero so
    // the first accumulate step adds nothing.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else begin
            if (r_state == S_MAC) begin
                r_prod <= w_prod;
            end
            if (r_state == S_MAC || r_state == S_FLUSH) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.result_channel <= r_ch;
            r_out.filtered       <= w_filt;
        end
    end

    // An accepted beat always starts the tap sweep at the oldest tap.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MAC) && (r_idx == LAST_IDX))
        else $error("tap sweep did not start at the oldest tap");

    // A new result only ever comes from the finishing state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without a finished sweep");

    // The finishing state never writes over a result that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && i_out_stall) |=> (r_state == S_DONE))
        else $error("finished sweep left while the output was stalled");

    // The tap count stays inside the filter length.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_idx <= LAST_IDX))
        else $error("tap index beyond the filter length");

endmodule
